// ===== sv/shortest_remaining_time_scheduler_macros.svh =====
// Assertion helpers for the checker file srtf_checker.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SRTS_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("srtf check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SRTS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("srtf check failed");

`endif

// ===== sv/srtf_pkg.sv =====
`default_nettype none
package srtf_pkg;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	localparam logic [23:0] MAX24 = 24'hFF_FFFF;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPLY,
		S_LAUNCH,
		S_SCAN,
		S_CALC1,
		S_CALC2,
		S_CALC3,
		S_OUT
	} state_t;

	// Running result handed from cell to cell during a scan.
	typedef struct packed {
		logic        tok;
		logic        found;
		logic        nz_any;
		logic        nz_many;
		logic [15:0] best;
		logic [15:0] arr;
		logic [15:0] burst;
	} scan_t;

	// Table commands broadcast to every cell.
	typedef struct packed {
		logic        load;
		logic        restart;
		logic        dec;
		logic [4:0]  slot;
		logic [15:0] arrival;
		logic [15:0] burst;
	} cmd_t;

endpackage
`default_nettype wire

// ===== sv/shortest_remaining_time_scheduler.sv =====
// An accepted item passes S_APPLY, S_LAUNCH, S_SCAN, S_CALC1-3 and S_OUT before its result is valid.
// The block takes no new item until the last one is through; the scan token walks the cell
// chain one cell per cycle, and each item takes one full walk.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low): remaining times, time, totals and process_count clear to 0;
// arrival and burst entries hold garbage until loaded.
`default_nettype none
module shortest_remaining_time_scheduler #(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  operation,
	input  logic [4:0]  slot,
	input  logic [15:0] arrival,
	input  logic [15:0] burst,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [23:0] now,
	output logic        ran,
	output logic [4:0]  chosen,
	output logic        finished,
	output logic [23:0] turnaround,
	output logic [23:0] waiting,
	output logic [31:0] sum_turnaround,
	output logic [31:0] sum_waiting,
	output logic        all_done
);

	localparam int IDX_W = $clog2(SLOTS);

	logic [5:0]       process_count_q;
	srtf_pkg::cmd_t   cmd;
	logic [IDX_W-1:0] dec_idx;
	logic [23:0]      clock_now;
	srtf_pkg::scan_t  chain [SLOTS+1];
	logic [IDX_W-1:0] chain_idx [SLOTS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q <= 6'd0;
		end else if (cfg_valid) begin
			process_count_q <= cfg_data;
		end
	end

	assign chain_idx[0] = '0;

	srtf_ctrl #(
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.operation      (operation),
		.slot           (slot),
		.arrival        (arrival),
		.burst          (burst),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.now            (now),
		.ran            (ran),
		.chosen         (chosen),
		.finished       (finished),
		.turnaround     (turnaround),
		.waiting        (waiting),
		.sum_turnaround (sum_turnaround),
		.sum_waiting    (sum_waiting),
		.all_done       (all_done),
		.cmd            (cmd),
		.dec_idx        (dec_idx),
		.clock_now      (clock_now),
		.head           (chain[0]),
		.tail           (chain[SLOTS]),
		.tail_idx       (chain_idx[SLOTS])
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		srtf_cell #(
			.IDX  (i),
			.IDX_W(IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.dec_idx   (dec_idx),
			.count     (process_count_q),
			.clock_now (clock_now),
			.prev      (chain[i]),
			.prev_idx  (chain_idx[i]),
			.scan      (chain[i+1]),
			.scan_idx  (chain_idx[i+1])
		);
	end

endmodule
`default_nettype wire

// ===== sv/srtf_cell.sv =====
`default_nettype none
module srtf_cell #(
	parameter int IDX   = 0,
	parameter int IDX_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srtf_pkg::cmd_t       cmd,
	input  logic [IDX_W-1:0]     dec_idx,
	input  logic [5:0]           count,
	input  logic [23:0]          clock_now,
	input  srtf_pkg::scan_t      prev,
	input  logic [IDX_W-1:0]     prev_idx,
	output srtf_pkg::scan_t      scan,
	output logic [IDX_W-1:0]     scan_idx
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [15:0]      arr_q;
	logic [15:0]      burst_q;
	logic [15:0]      rem_q;
	srtf_pkg::scan_t  scan_q;
	logic [IDX_W-1:0] idx_q;

	logic            active;
	logic            nz;
	logic            elig;
	logic            take;
	srtf_pkg::scan_t nxt;

	assign active = 32'(count) > 32'(IDX);
	assign nz     = active && (rem_q != 16'd0);
	assign elig   = nz && ({8'h00, arr_q} <= clock_now);
	assign take   = elig && (!prev.found || (rem_q < prev.best));

	always_comb begin
		nxt         = prev;
		nxt.found   = prev.found | elig;
		nxt.nz_any  = prev.nz_any | nz;
		nxt.nz_many = prev.nz_many | (prev.nz_any & nz);
		if (take) begin
			nxt.best  = rem_q;
			nxt.arr   = arr_q;
			nxt.burst = burst_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (32'(cmd.slot) == 32'(IDX))) begin
			arr_q   <= cmd.arrival;
			burst_q <= cmd.burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 16'd0;
		end else if (cmd.restart && active) begin
			rem_q <= burst_q;
		end else if (cmd.dec && (dec_idx == MY_IDX)) begin
			rem_q <= rem_q - 16'd1;
		end
	end

	// the token rides along with the running result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= take ? MY_IDX : prev_idx;
	end

	assign scan     = scan_q;
	assign scan_idx = idx_q;

endmodule
`default_nettype wire

// ===== sv/srtf_ctrl.sv =====
`default_nettype none
module srtf_ctrl #(
	parameter int IDX_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [1:0]           operation,
	input  logic [4:0]           slot,
	input  logic [15:0]          arrival,
	input  logic [15:0]          burst,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [23:0]          now,
	output logic                 ran,
	output logic [4:0]           chosen,
	output logic                 finished,
	output logic [23:0]          turnaround,
	output logic [23:0]          waiting,
	output logic [31:0]          sum_turnaround,
	output logic [31:0]          sum_waiting,
	output logic                 all_done,
	output srtf_pkg::cmd_t       cmd,
	output logic [IDX_W-1:0]     dec_idx,
	output logic [23:0]          clock_now,
	output srtf_pkg::scan_t      head,
	input  srtf_pkg::scan_t      tail,
	input  logic [IDX_W-1:0]     tail_idx
);

	srtf_pkg::state_t state_q, state_d;

	logic [1:0]       op_q;
	logic [4:0]       slot_q;
	logic [15:0]      arr_q;
	logic [15:0]      burst_q;
	logic [23:0]      clock_q;
	logic [31:0]      sum_tat_q;
	logic [31:0]      sum_wait_q;
	srtf_pkg::scan_t  snap_q;
	logic [IDX_W-1:0] snap_idx_q;
	logic [23:0]      before_q;
	logic [23:0]      tat_q;
	logic [23:0]      wait_q;
	logic             fin_q;
	logic             done_q;
	logic             out_valid_q;

	logic [23:0] r_now_q;
	logic        r_ran_q;
	logic [4:0]  r_chosen_q;
	logic        r_fin_q;
	logic [23:0] r_tat_q;
	logic [23:0] r_wait_q;
	logic [31:0] r_sum_tat_q;
	logic [31:0] r_sum_wait_q;
	logic        r_done_q;

	logic        accept;
	logic        load_out;
	logic        is_tick;
	logic        ran_now;
	logic        fin_now;
	logic [24:0] tat_full;
	logic [32:0] sum_tat_full;
	logic [32:0] sum_wait_full;

	assign accept   = item_valid && item_ready;
	assign is_tick  = (op_q == srtf_pkg::OP_TICK);
	assign ran_now  = is_tick && snap_q.found;
	assign fin_now  = ran_now && (snap_q.best == 16'd1);
	assign tat_full = 25'(before_q) + 25'd1 - 25'(snap_q.arr);
	assign sum_tat_full  = 33'(sum_tat_q) + 33'(tat_q);
	assign sum_wait_full = 33'(sum_wait_q) + 33'(wait_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srtf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		load_out    = 1'b0;
		cmd.load    = 1'b0;
		cmd.restart = 1'b0;
		cmd.dec     = 1'b0;
		cmd.slot    = slot_q;
		cmd.arrival = arr_q;
		cmd.burst   = burst_q;
		head        = '0;
		unique case (state_q)
			srtf_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = srtf_pkg::S_APPLY;
				end
			end
			srtf_pkg::S_APPLY: begin
				cmd.load    = (op_q == srtf_pkg::OP_LOAD);
				cmd.restart = (op_q == srtf_pkg::OP_RESTART);
				state_d     = srtf_pkg::S_LAUNCH;
			end
			srtf_pkg::S_LAUNCH: begin
				head.tok = 1'b1;
				state_d  = srtf_pkg::S_SCAN;
			end
			srtf_pkg::S_SCAN: begin
				if (tail.tok) begin
					state_d = srtf_pkg::S_CALC1;
				end
			end
			srtf_pkg::S_CALC1: begin
				cmd.dec = ran_now;
				state_d = srtf_pkg::S_CALC2;
			end
			srtf_pkg::S_CALC2: begin
				state_d = srtf_pkg::S_CALC3;
			end
			srtf_pkg::S_CALC3: begin
				state_d = srtf_pkg::S_OUT;
			end
			srtf_pkg::S_OUT: begin
				if (!out_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = srtf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = srtf_pkg::S_IDLE;
			end
		endcase
	end

	// time, totals and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= 24'd0;
			sum_tat_q   <= 32'd0;
			sum_wait_q  <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == srtf_pkg::S_APPLY && op_q == srtf_pkg::OP_RESTART) begin
				clock_q    <= 24'd0;
				sum_tat_q  <= 32'd0;
				sum_wait_q <= 32'd0;
			end
			if (state_q == srtf_pkg::S_CALC1 && is_tick && clock_q != srtf_pkg::MAX24) begin
				clock_q <= clock_q + 24'd1;
			end
			if (state_q == srtf_pkg::S_CALC2 && fin_q) begin
				sum_tat_q <= sum_tat_full[32] ? srtf_pkg::MAX32 : sum_tat_full[31:0];
			end
			if (state_q == srtf_pkg::S_CALC3 && fin_q) begin
				sum_wait_q <= sum_wait_full[32] ? srtf_pkg::MAX32 : sum_wait_full[31:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			slot_q  <= slot;
			arr_q   <= arrival;
			burst_q <= burst;
		end
		if (state_q == srtf_pkg::S_SCAN && tail.tok) begin
			snap_q     <= tail;
			snap_idx_q <= tail_idx;
			before_q   <= clock_q;
		end
		if (state_q == srtf_pkg::S_CALC1) begin
			fin_q  <= fin_now;
			tat_q  <= tat_full[24] ? srtf_pkg::MAX24 : tat_full[23:0];
			// all done when no task has work left, or the chosen task finishes and is the only nonzero one left
			done_q <= !snap_q.nz_any || (fin_now && !snap_q.nz_many);
		end
		if (state_q == srtf_pkg::S_CALC2) begin
			wait_q <= (tat_q > {8'h00, snap_q.burst}) ? tat_q - {8'h00, snap_q.burst} : 24'd0;
		end
		if (load_out) begin
			r_now_q      <= before_q;
			r_ran_q      <= ran_now;
			r_chosen_q   <= ran_now ? 5'(snap_idx_q) : 5'd0;
			r_fin_q      <= fin_q;
			r_tat_q      <= fin_q ? tat_q : 24'd0;
			r_wait_q     <= fin_q ? wait_q : 24'd0;
			r_sum_tat_q  <= sum_tat_q;
			r_sum_wait_q <= sum_wait_q;
			r_done_q     <= done_q;
		end
	end

	assign dec_idx        = snap_idx_q;
	assign clock_now      = clock_q;
	assign result_valid   = out_valid_q;
	assign now            = r_now_q;
	assign ran            = r_ran_q;
	assign chosen         = r_chosen_q;
	assign finished       = r_fin_q;
	assign turnaround     = r_tat_q;
	assign waiting        = r_wait_q;
	assign sum_turnaround = r_sum_tat_q;
	assign sum_waiting    = r_sum_wait_q;
	assign all_done       = r_done_q;

endmodule
`default_nettype wire

// ===== sv/srtf_checker.sv =====
`default_nettype none
`include "shortest_remaining_time_scheduler_macros.svh"
module srtf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [5:0]  cfg_data,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  operation,
	input logic [4:0]  slot,
	input logic [15:0] arrival,
	input logic [15:0] burst,
	input logic        result_valid,
	input logic        result_ready,
	input logic [23:0] now,
	input logic        ran,
	input logic [4:0]  chosen,
	input logic        finished,
	input logic [23:0] turnaround,
	input logic [23:0] waiting,
	input logic [31:0] sum_turnaround,
	input logic [31:0] sum_waiting,
	input logic        all_done
);

	// one item in flight at a time
	`SRTS_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready)

	`SRTS_ASSERT_IMPL(a_idle_fields_clear, result_valid && !ran,
		chosen == 5'd0 && !finished && turnaround == 24'd0 && waiting == 24'd0)

	`SRTS_ASSERT_IMPL(a_finish_consistent, result_valid && finished,
		ran && waiting <= turnaround && turnaround != 24'd0)

	`SRTS_ASSERT_NEXT(a_result_held, result_valid && !result_ready,
		result_valid && $stable(now) && $stable(sum_turnaround) && $stable(all_done))

endmodule

bind shortest_remaining_time_scheduler srtf_checker u_srtf_checker (.*);
`default_nettype wire

// ===== dv/shortest_remaining_time_scheduler_tb.sv =====
module shortest_remaining_time_scheduler_tb;

	localparam logic [1:0] OP_LOAD = srtf_pkg::OP_LOAD;
	localparam logic [1:0] OP_RESTART = srtf_pkg::OP_RESTART;
	localparam logic [1:0] OP_TICK = srtf_pkg::OP_TICK;
	localparam logic [23:0] MAX24 = srtf_pkg::MAX24;
	localparam logic [31:0] MAX32 = srtf_pkg::MAX32;

	localparam int NUM_SLOTS = 32;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Longest legitimate quiet spell is the receiver's long hold-off plus one item latency.
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 45;
	localparam int RANDOM_ITEMS = 500;
	localparam int CALM_ITEMS = 100;
	localparam int TICK_CAP = 48;

	typedef struct packed {
		logic [23:0] now;
		logic        ran;
		logic [4:0]  chosen;
		logic        finished;
		logic [23:0] turnaround;
		logic [23:0] waiting;
		logic [31:0] sum_turnaround;
		logic [31:0] sum_waiting;
		logic        all_done;
	} slice_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  operation = OP_LOAD;
	logic [4:0]  slot = '0;
	logic [15:0] arrival = '0;
	logic [15:0] burst = '0;
	logic        result_valid;
	logic        result_ready;
	logic [23:0] now;
	logic        ran;
	logic [4:0]  chosen;
	logic        finished;
	logic [23:0] turnaround;
	logic [23:0] waiting;
	logic [31:0] sum_turnaround;
	logic [31:0] sum_waiting;
	logic        all_done;

	shortest_remaining_time_scheduler #(
		.SLOTS(NUM_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.slot(slot),
		.arrival(arrival),
		.burst(burst),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.now(now),
		.ran(ran),
		.chosen(chosen),
		.finished(finished),
		.turnaround(turnaround),
		.waiting(waiting),
		.sum_turnaround(sum_turnaround),
		.sum_waiting(sum_waiting),
		.all_done(all_done)
	);

	// Mirror of the task table and run state
	logic [15:0] task_arrival [NUM_SLOTS];
	logic [15:0] task_burst [NUM_SLOTS];
	logic [15:0] task_left [NUM_SLOTS];
	logic [23:0] sim_now = '0;
	logic [31:0] total_tat = '0;
	logic [31:0] total_wait = '0;
	logic [5:0]  slot_count = '0;
	logic        last_all_done = 1'b1;

	slice_report_t slice_reports_due [$];
	slice_report_t due_report;

	int  errors = 0;
	int  items_sent = 0;
	int  quiet_cycles = 0;
	int  hold_cycles = 0;
	bit  idle_on = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? MAX32 : s[31:0];
	endfunction

	// One scheduler step: updates the mirrored state and returns the report due.
	function automatic slice_report_t srtf_step(input logic [1:0] op, input logic [4:0] sl,
			input logic [15:0] ar, input logic [15:0] bu);
		slice_report_t r;
		int n;
		logic found;
		logic [15:0] best;
		logic [4:0] pick;
		logic [24:0] tat;
		r = '0;
		found = 1'b0;
		best = '0;
		pick = '0;
		n = (slot_count > NUM_SLOTS) ? NUM_SLOTS : int'(slot_count);
		r.now = sim_now;
		case (op)
			OP_LOAD: begin
				task_arrival[sl] = ar;
				task_burst[sl] = bu;
			end
			OP_RESTART: begin
				sim_now = '0;
				total_tat = '0;
				total_wait = '0;
				for (int i = 0; i < n; i++)
					task_left[i] = task_burst[i];
				r.now = '0;
			end
			OP_TICK: begin
				for (int i = 0; i < n; i++) begin
					if (task_left[i] != 0 && {8'd0, task_arrival[i]} <= sim_now &&
							(!found || task_left[i] < best)) begin
						found = 1'b1;
						best = task_left[i];
						pick = 5'(i);
					end
				end
				if (found) begin
					r.ran = 1'b1;
					r.chosen = pick;
					task_left[pick] = task_left[pick] - 16'd1;
					if (task_left[pick] == 0) begin
						r.finished = 1'b1;
						tat = {1'b0, sim_now} + 25'd1 - {9'd0, task_arrival[pick]};
						r.turnaround = (tat > {1'b0, MAX24}) ? MAX24 : tat[23:0];
						r.waiting = (r.turnaround > {8'd0, task_burst[pick]}) ?
							r.turnaround - {8'd0, task_burst[pick]} : '0;
						total_tat = add_sat32(total_tat, {8'd0, r.turnaround});
						total_wait = add_sat32(total_wait, {8'd0, r.waiting});
					end
				end
				if (sim_now != MAX24)
					sim_now = sim_now + 24'd1;
			end
			default: ;
		endcase
		r.sum_turnaround = total_tat;
		r.sum_waiting = total_wait;
		r.all_done = 1'b1;
		for (int i = 0; i < n; i++)
			if (task_left[i] != 0)
				r.all_done = 1'b0;
		last_all_done = r.all_done;
		return r;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [4:0] sl,
			input logic [15:0] ar, input logic [15:0] bu);
		operation <= op;
		slot <= sl;
		arrival <= ar;
		burst <= bu;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		slice_reports_due.push_back(srtf_step(op, sl, ar, bu));
		items_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Sender stops until every outstanding report is back
	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (slice_reports_due.size() != 0);
	endtask

	task automatic write_count(input logic [5:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		slot_count = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_item(OP_UNUSED, 5'($urandom), 16'($urandom), 16'($urandom));
			1: send_item(OP_LOAD, 5'($urandom), 16'($urandom), 16'($urandom));
			2: send_item(OP_RESTART, 5'($urandom), 16'($urandom), 16'($urandom));
			default: send_item(OP_LOAD, 5'($urandom), 16'($urandom_range(0, 12)),
				16'($urandom_range(1, 5)));
		endcase
	endtask

	// Tick until every counted task is done (or the cap), then one or two more ticks.
	task automatic run_ticks(input int cap, input bit noisy);
		int sent;
		sent = 0;
		while (sent < cap && !last_all_done) begin
			if (noisy && $urandom_range(0, 9) == 0) begin
				send_noise();
			end else begin
				send_item(OP_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
				sent++;
			end
		end
		repeat ($urandom_range(1, 2))
			send_item(OP_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic test_idle_and_unused();
		// count still zero: ticks are idle but time moves on
		send_item(OP_TICK, '1, '1, '1);
		send_item(OP_TICK, '0, '0, '0);
		send_item(OP_UNUSED, 5'd17, 16'hA5A5, 16'h5A5A);
		send_item(OP_RESTART, '1, '1, '1);
		send_item(OP_TICK, 5'd9, 16'h1234, 16'h4321);
	endtask

	task automatic test_fill_table();
		for (int i = 0; i < NUM_SLOTS; i++)
			send_item(OP_LOAD, 5'(i), 16'(i % 4), 16'(i % 5 + 1));
		send_item(OP_LOAD, 5'd0, 16'd0, 16'd0);
		send_item(OP_LOAD, 5'd31, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_basic_run();
		drain_results();
		write_count(6'd4);
		// slots 1 and 2 tie, slot 3 arrives later with the shortest job; slot 0 has no work
		send_item(OP_LOAD, 5'd1, 16'd0, 16'd3);
		send_item(OP_LOAD, 5'd2, 16'd0, 16'd3);
		send_item(OP_LOAD, 5'd3, 16'd2, 16'd1);
		send_item(OP_RESTART, '0, '0, '0);
		run_ticks(16, 1'b0);
	endtask

	task automatic test_reload_midrun();
		drain_results();
		send_item(OP_RESTART, 5'd3, 16'd7, 16'd7);
		send_item(OP_TICK, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0);
		// loads leave the remaining time alone: huge burst floors the waiting time
		send_item(OP_LOAD, 5'd2, 16'd0, 16'hFFFF);
		send_item(OP_LOAD, 5'd3, 16'd40, 16'd1);
		run_ticks(60, 1'b0);
	endtask

	task automatic test_count_limits();
		drain_results();
		write_count(6'd63);
		send_item(OP_RESTART, '0, '0, '0);
		repeat (3) send_item(OP_TICK, '0, '0, '0);
		drain_results();
		// slots beyond the count keep their remaining times over a restart
		write_count(6'd2);
		send_item(OP_RESTART, '0, '0, '0);
		run_ticks(12, 1'b0);
		drain_results();
		write_count(6'd32);
		repeat (2) send_item(OP_TICK, '0, '0, '0);
	endtask

	task automatic test_backpressure();
		drain_results();
		write_count(6'd5);
		for (int i = 0; i < 5; i++)
			send_item(OP_LOAD, 5'(i), 16'(i), 16'(i + 1));
		send_item(OP_RESTART, '0, '0, '0);
		hold_cycles = 300;
		repeat (8) send_item(OP_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
		drain_results();
	endtask

	task automatic random_phase(input bit noisy);
		int n;
		drain_results();
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 19))
				0: write_count(6'd0);
				1: write_count(6'd63);
				2: write_count(6'd32);
				3, 4: write_count(6'($urandom_range(33, 63)));
				5, 6, 7: write_count(6'($urandom_range(9, 31)));
				default: write_count(6'($urandom_range(1, 8)));
			endcase
		end
		n = (slot_count > NUM_SLOTS) ? NUM_SLOTS : int'(slot_count);
		for (int i = 0; i < n; i++)
			send_item(OP_LOAD, 5'(i), 16'($urandom_range(0, 12)),
				16'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5)));
		send_item(OP_RESTART, 5'($urandom), 16'($urandom), 16'($urandom));
		run_ticks(TICK_CAP, noisy);
	endtask

	task automatic test_random_runs(input int target, input bit allow_idle);
		while (items_sent < target) begin
			idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			random_phase(allow_idle);
		end
	endtask

	// Receiver: random short stalls, or one long hold-off on request
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				result_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (slice_reports_due.size() == 0) begin
				$error("report with no item outstanding");
				errors++;
			end else begin
				due_report = slice_reports_due.pop_front();
				check_field("now", 32'(due_report.now), 32'(now));
				check_field("ran", 32'(due_report.ran), 32'(ran));
				check_field("chosen", 32'(due_report.chosen), 32'(chosen));
				check_field("finished", 32'(due_report.finished), 32'(finished));
				check_field("turnaround", 32'(due_report.turnaround), 32'(turnaround));
				check_field("waiting", 32'(due_report.waiting), 32'(waiting));
				check_field("sum_turnaround", due_report.sum_turnaround, sum_turnaround);
				check_field("sum_waiting", due_report.sum_waiting, sum_waiting);
				check_field("all_done", 32'(due_report.all_done), 32'(all_done));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
		$display("shortest_remaining_time_scheduler_tb: done, errors");
		$finish;
	end

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++)
			task_left[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_unused();
		test_fill_table();
		test_basic_run();
		test_reload_midrun();
		test_count_limits();
		test_backpressure();
		test_random_runs(items_sent + RANDOM_ITEMS, 1'b1);
		idle_on = 1'b0;
		test_random_runs(items_sent + CALM_ITEMS, 1'b0);
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && slice_reports_due.size() == 0)
			$display("shortest_remaining_time_scheduler_tb: done, clean");
		else
			$display("shortest_remaining_time_scheduler_tb: done, errors");
		$finish;
	end

endmodule
